### hw/rtl/mfmd_pkg.sv
`default_nettype none

package mfmd_pkg;

   // Configuration port widths and register indexes.
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_BASE_ID     = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_WRAP_WINDOW = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] REG_DEADBAND    = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] REG_FILTER_GAIN = CSR_ADDR_W'(3);

   // Register values after reset.
   localparam logic [10:0] BASE_ID_RESET     = 11'd513;
   localparam logic [11:0] WRAP_WINDOW_RESET = 12'd1000;
   localparam logic [14:0] DEADBAND_RESET    = 15'd10;
   localparam logic [8:0]  FILTER_GAIN_RESET = 9'd154;

   // Frame acceptance rules.
   localparam int          NUM_IDS      = 8;
   localparam logic [3:0]  FRAME_LENGTH = 4'd8;
   localparam logic [8:0]  GAIN_ONE     = 9'd256;

   typedef struct packed {
      logic               standard_frame;
      logic [3:0]         frame_length;
      logic [10:0]        frame_id;
      logic [15:0]        angle_raw;
      logic signed [15:0] speed_raw;
      logic signed [15:0] current_raw;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         motor_slot;
      logic signed [31:0] position;
      logic signed [15:0] speed;
      logic signed [23:0] current_filtered;
   } rsp_payload_type;

   // Values strictly inside (-d, d) are forced to zero.
   function automatic logic signed [15:0] apply_deadband(input logic signed [15:0] x,
                                                         input logic [14:0] d);
      logic signed [16:0] xs;
      logic signed [16:0] ds;
      xs = 17'(x);
      ds = signed'({2'b00, d});
      if ((xs < ds) && (xs > -ds)) begin
         return 16'sd0;
      end
      return x;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/mfmd_current_filter.sv
`default_nettype none

module mfmd_current_filter
   import mfmd_pkg::*;
(
   input  wire logic signed [23:0] state_cur,
   input  wire logic signed [15:0] current_raw,
   input  wire logic [14:0]        deadband,
   input  wire logic [8:0]         filter_gain,
   output logic signed [23:0]      state_next
);

   logic [8:0]         gain_new;
   logic [8:0]         gain_old;
   logic signed [15:0] cur_db;
   logic signed [33:0] prod_old;
   logic signed [25:0] prod_new;
   logic signed [34:0] acc;
   logic signed [26:0] quot;

   // Clamp the gain to one and split it into old and new weights.
   always_comb begin
      gain_new = (filter_gain > GAIN_ONE) ? GAIN_ONE : filter_gain;
      gain_old = GAIN_ONE - gain_new;
   end

   // Weighted mean in Q15.8, rounded half up, then floor by 256.
   always_comb begin
      cur_db   = apply_deadband(current_raw, deadband);
      prod_old = state_cur * signed'({1'b0, gain_old});
      prod_new = cur_db * signed'({1'b0, gain_new});
      acc      = 35'(prod_old) + (35'(prod_new) <<< 8) + 35'sd128;
      quot     = acc[34:8];
   end

   // Saturate to the signed 24-bit range.
   always_comb begin
      if (quot > 27'sd8388607) begin
         state_next = 24'sh7FFFFF;
      end else if (quot < -27'sd8388608) begin
         state_next = 24'sh800000;
      end else begin
         state_next = quot[23:0];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/motor_feedback_multiturn_decoder.sv
`default_nettype none
// A request is held in the request register and its result then in the result register.
// One request per cycle while rsp_stall is low; slot state is read and written in the same cycle.
// Requests that fail the frame checks leave the request register without a result.
// Reset clears all slot state at once and loads the register defaults; no clearing pass.

module motor_feedback_multiturn_decoder
   import mfmd_pkg::*;
#(
   parameter int SLOTS          = 8,
   parameter int COUNTS_PER_REV = 8192
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NUM_USED = (SLOTS < NUM_IDS) ? SLOTS : NUM_IDS;
   localparam int SLOT_W   = (NUM_USED > 1) ? $clog2(NUM_USED) : 1;
   localparam logic [31:0]        CPR32 = 32'(COUNTS_PER_REV);
   localparam logic signed [17:0] CPR_S = 18'(COUNTS_PER_REV);

   // Configuration registers.
   logic [10:0] base_id_ff;
   logic [11:0] wrap_window_ff;
   logic [14:0] deadband_ff;
   logic [8:0]  filter_gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff     <= BASE_ID_RESET;
         wrap_window_ff <= WRAP_WINDOW_RESET;
         deadband_ff    <= DEADBAND_RESET;
         filter_gain_ff <= FILTER_GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BASE_ID:     base_id_ff     <= csr_data[10:0];
            REG_WRAP_WINDOW: wrap_window_ff <= csr_data[11:0];
            REG_DEADBAND:    deadband_ff    <= csr_data[14:0];
            REG_FILTER_GAIN: filter_gain_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // Request register.
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_ff;
   logic            fire;
   logic            frame_ok;
   logic            out_free;
   logic            out_load;
   logic            req_take;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign fire      = in_valid_ff && (!frame_ok || out_free);
   assign out_load  = fire && frame_ok;
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_payload;
      end
   end

   // Frame check and slot selection.
   logic [10:0]       id_diff;
   logic [SLOT_W-1:0] slot_idx;

   always_comb begin
      id_diff  = in_ff.frame_id - base_id_ff;
      slot_idx = id_diff[SLOT_W-1:0];
      frame_ok = in_ff.standard_frame && (in_ff.frame_length == FRAME_LENGTH)
                 && (in_ff.frame_id >= base_id_ff) && (id_diff < 11'(NUM_USED));
   end

   // Per-slot state.
   logic [15:0]        last_angle_ff      [NUM_USED];
   logic [31:0]        revolutions_ff     [NUM_USED];
   logic [31:0]        zero_offset_ff     [NUM_USED];
   logic               offset_captured_ff [NUM_USED];
   logic signed [23:0] current_state_ff   [NUM_USED];

   // Wrap detection against the previous angle of the slot.
   logic signed [17:0] upper_s;
   logic signed [17:0] angle_s;
   logic signed [17:0] last_s;
   logic               wrap_up;
   logic               wrap_down;
   logic [15:0]        last_angle;
   logic [31:0]        rev_cur;
   logic [31:0]        rev_in;
   logic [31:0]        rev_scaled;
   logic [31:0]        pos;
   logic               capture;

   always_comb begin
      last_angle = last_angle_ff[slot_idx];
      rev_cur    = revolutions_ff[slot_idx];
      upper_s    = CPR_S - signed'({6'b0, wrap_window_ff});
      angle_s    = signed'({2'b00, in_ff.angle_raw});
      last_s     = signed'({2'b00, last_angle});
      wrap_up    = (in_ff.angle_raw < 16'(wrap_window_ff)) && (last_s > upper_s);
      wrap_down  = !wrap_up && (angle_s > upper_s) && (last_angle < 16'(wrap_window_ff));
   end

   // Absolute position; the scaled count is formed from the old count plus or minus one turn on a wrap.
   always_comb begin
      rev_in     = rev_cur;
      rev_scaled = rev_cur * CPR32;
      if (wrap_up) begin
         rev_in     = rev_cur + 32'd1;
         rev_scaled = rev_scaled + CPR32;
      end else if (wrap_down) begin
         rev_in     = rev_cur - 32'd1;
         rev_scaled = rev_scaled - CPR32;
      end
      pos     = 32'(in_ff.angle_raw) + rev_scaled - zero_offset_ff[slot_idx];
      capture = !offset_captured_ff[slot_idx] && (pos != 32'd0);
   end

   // Current filter.
   logic signed [23:0] current_next;

   mfmd_current_filter u_filter (
      .state_cur   (current_state_ff[slot_idx]),
      .current_raw (in_ff.current_raw),
      .deadband    (deadband_ff),
      .filter_gain (filter_gain_ff),
      .state_next  (current_next)
   );

   // Slot state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_USED; i++) begin
            last_angle_ff[i]      <= 16'd0;
            revolutions_ff[i]     <= 32'd0;
            zero_offset_ff[i]     <= 32'd0;
            offset_captured_ff[i] <= 1'b0;
            current_state_ff[i]   <= 24'sd0;
         end
      end else if (out_load) begin
         last_angle_ff[slot_idx]    <= in_ff.angle_raw;
         revolutions_ff[slot_idx]   <= rev_in;
         current_state_ff[slot_idx] <= current_next;
         if (capture) begin
            zero_offset_ff[slot_idx]     <= pos;
            offset_captured_ff[slot_idx] <= 1'b1;
         end
      end
   end

   // Result register.
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_ff;

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff.motor_slot       <= 3'(id_diff);
         rsp_ff.position         <= signed'(pos);
         rsp_ff.speed            <= apply_deadband(in_ff.speed_raw, deadband_ff);
         rsp_ff.current_filtered <= current_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The request side is held back only while the request register is occupied.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stall raised with an empty request register");

   // A loaded result is presented in the next cycle.
   a_load_gives_result: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("result load did not raise rsp_valid");

   // A good frame blocked by a full result register stays in the request register.
   a_blocked_item_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && frame_ok && !out_free) |=> in_valid_ff)
      else $error("blocked request was dropped");

   // A result can only appear after a request was in the request register.
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(in_valid_ff))
      else $error("result appeared without a request");

endmodule

`default_nettype wire
